>>> rtl/core/dmbm_pkg.sv
package dmbm_pkg;

  // request codes
  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_ADD     = 2'd1;
  localparam logic [1:0] REQ_MATCH   = 2'd2;
  localparam logic [1:0] REQ_LARGEST = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_INELIG = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // eligibility constants
  localparam logic [7:0] BPP_MAX    = 8'd32;
  localparam logic [7:0] BPP_15     = 8'd15;
  localparam logic [7:0] MM_PACKED  = 8'd4;
  localparam logic [7:0] MM_DIRECT  = 8'd6;

  localparam logic [31:0] FB_LIMIT_RESET = 32'd16777216;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] mode_number;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  bits_per_pixel;
    logic [15:0] pitch_bytes;
    logic        attr_supported;
    logic        attr_linear;
    logic        attr_graphics;
    logic        fb_address_nonzero;
    logic [7:0]  mem_layout;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        exact_match;
    logic [15:0] out_mode_number;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [7:0]  out_bpp;
    logic [6:0]  entry_count;
  } out_item_t;

  // one stored mode
  typedef struct packed {
    logic [15:0] mode_number;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  bpp;
  } entry_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [1:0] req_type;
    logic       eligible;
    entry_t     mode;
  } cmd_t;

endpackage

>>> rtl/core/dmbm_front.sv
module dmbm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dmbm_pkg::in_item_t  in_item_i,
  input  logic [31:0]         fb_limit_i,
  output logic                push_o,
  output dmbm_pkg::cmd_t      push_cmd_o,
  input  logic                full_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_CHK  = 2'd2;

  logic [1:0]         state_q, state_d;
  dmbm_pkg::in_item_t item_q;
  logic [31:0]        prod_q;
  logic [39:0]        need_full;
  logic [36:0]        need;
  logic               attr_ok, bpp_ok, mm_ok, size_ok;

  assign in_stall_o = (state_q != F_IDLE);

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_MUL;
      end
      F_MUL: begin
        state_d = F_CHK;
      end
      F_CHK: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pitch * height, then times bpp in the check cycle
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) item_q <= in_item_i;
    if (state_q == F_MUL) prod_q <= 32'(item_q.pitch_bytes) * 32'(item_q.height);
  end

  assign need_full = 40'(prod_q) * 40'(item_q.bits_per_pixel);
  assign need      = need_full[39:3];

  assign attr_ok = item_q.attr_supported & item_q.attr_linear & item_q.attr_graphics &
                   item_q.fb_address_nonzero;
  assign bpp_ok  = ((item_q.bits_per_pixel[2:0] == 3'd0) ||
                    (item_q.bits_per_pixel == dmbm_pkg::BPP_15)) &&
                   (item_q.bits_per_pixel <= dmbm_pkg::BPP_MAX);
  assign size_ok = (need <= {5'd0, fb_limit_i});
  assign mm_ok   = (item_q.mem_layout == dmbm_pkg::MM_PACKED) ||
                   (item_q.mem_layout == dmbm_pkg::MM_DIRECT);

  always_comb begin
    push_cmd_o.req_type         = item_q.req_type;
    push_cmd_o.eligible         = attr_ok & bpp_ok & size_ok & mm_ok;
    push_cmd_o.mode.mode_number = item_q.mode_number;
    push_cmd_o.mode.width       = item_q.width;
    push_cmd_o.mode.height      = item_q.height;
    push_cmd_o.mode.bpp         = item_q.bits_per_pixel;
  end

endmodule

>>> rtl/core/dmbm_queue.sv
module dmbm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dmbm_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  output logic            valid_o,
  output dmbm_pkg::cmd_t  cmd_o,
  input  logic            pop_i
);

  // two entries
  dmbm_pkg::cmd_t slot_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     fill_q;
  logic           do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      if (do_push && !do_pop) fill_q <= fill_q + 2'd1;
      else if (!do_push && do_pop) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= push_cmd_i;
  end

endmodule

>>> rtl/core/dmbm_back.sv
module dmbm_back #(
  parameter int MAX_MODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  dmbm_pkg::cmd_t      q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dmbm_pkg::out_item_t out_item_o
);

  localparam int CW = $clog2(MAX_MODES + 1);
  localparam int AW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SCAN = 2'd1;
  localparam logic [1:0] B_OUT  = 2'd2;

  logic [1:0]          state_q;
  logic [CW-1:0]       count_q;
  dmbm_pkg::cmd_t      cur_q;
  logic [31:0]         req_area_q;
  dmbm_pkg::out_item_t res_q, out_q;
  dmbm_pkg::out_item_t res_d, out_d;
  logic                out_valid_q;
  logic [CW+6:0]       count_ext;
  logic                slot_free;

  // mode table
  dmbm_pkg::entry_t    mem_q [MAX_MODES];
  logic                wr_en;
  logic [AW-1:0]       wr_addr;

  // scan pipeline
  logic                issuing_q;
  logic [AW-1:0]       addr_q;
  dmbm_pkg::entry_t    e1_q, e2_q, e3_q;
  logic                v1_q, v2_q, v3_q;
  logic [31:0]         area2_q, metric3_q;
  logic                eq2_q, eq3_q;
  logic [31:0]         delta2;
  logic                largest;

  // best so far
  logic                ex_found_q, nr_found_q;
  dmbm_pkg::entry_t    ex_best_q, nr_best_q;
  logic [31:0]         nr_metric_q;
  logic                ex_take, nr_take, scan_done;

  assign count_ext   = {7'd0, count_q};
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign q_pop_o     = (state_q == B_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign largest     = (cur_q.req_type == dmbm_pkg::REQ_LARGEST);

  assign wr_en   = q_pop_o && (q_cmd_i.req_type == dmbm_pkg::REQ_ADD) && q_cmd_i.eligible &&
                   (count_q != CW'(MAX_MODES));
  assign wr_addr = count_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= q_cmd_i.mode;
    e1_q <= mem_q[addr_q];
  end

  assign delta2 = (area2_q < req_area_q) ? (req_area_q - area2_q) : (area2_q - req_area_q);

  assign ex_take = v3_q && eq3_q && (!ex_found_q || (e3_q.bpp > ex_best_q.bpp));
  always_comb begin
    if (largest) begin
      nr_take = v3_q && (!nr_found_q || (metric3_q > nr_metric_q));
    end else begin
      nr_take = v3_q && (!nr_found_q || (metric3_q < nr_metric_q) ||
                ((metric3_q == nr_metric_q) && (e3_q.bpp > nr_best_q.bpp)));
    end
  end

  assign scan_done = !issuing_q && !v1_q && !v2_q && !v3_q;

  // result contents: status when the item is popped, chosen entry when the scan ends
  always_comb begin
    res_d = res_q;
    if (state_q == B_IDLE) begin
      res_d = '0;
      case (q_cmd_i.req_type)
        dmbm_pkg::REQ_CLEAR: res_d.status = dmbm_pkg::ST_OK;
        dmbm_pkg::REQ_ADD: begin
          if (!q_cmd_i.eligible) res_d.status = dmbm_pkg::ST_INELIG;
          else if (count_q == CW'(MAX_MODES)) res_d.status = dmbm_pkg::ST_FULL;
          else res_d.status = dmbm_pkg::ST_OK;
        end
        default: begin
          if (count_q == '0) res_d.status = dmbm_pkg::ST_NONE;
        end
      endcase
    end else begin
      res_d.status = dmbm_pkg::ST_OK;
      if (!largest && ex_found_q) begin
        res_d.exact_match     = 1'b1;
        res_d.out_mode_number = ex_best_q.mode_number;
        res_d.out_width       = ex_best_q.width;
        res_d.out_height      = ex_best_q.height;
        res_d.out_bpp         = ex_best_q.bpp;
      end else begin
        res_d.exact_match     = 1'b0;
        res_d.out_mode_number = nr_best_q.mode_number;
        res_d.out_width       = nr_best_q.width;
        res_d.out_height      = nr_best_q.height;
        res_d.out_bpp         = nr_best_q.bpp;
      end
    end
    out_d             = res_q;
    out_d.entry_count = count_ext[6:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      issuing_q   <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      ex_found_q  <= 1'b0;
      nr_found_q  <= 1'b0;
    end else begin
      v1_q <= issuing_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (state_q == B_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            ex_found_q <= 1'b0;
            nr_found_q <= 1'b0;
            case (q_cmd_i.req_type)
              dmbm_pkg::REQ_CLEAR: begin
                count_q <= '0;
                state_q <= B_OUT;
              end
              dmbm_pkg::REQ_ADD: begin
                if (wr_en) count_q <= count_q + CW'(1);
                state_q <= B_OUT;
              end
              default: begin
                if (count_q == '0) begin
                  state_q <= B_OUT;
                end else begin
                  issuing_q <= 1'b1;
                  state_q   <= B_SCAN;
                end
              end
            endcase
          end
        end
        B_SCAN: begin
          if (issuing_q && (addr_q == '0)) issuing_q <= 1'b0;
          if (ex_take) ex_found_q <= 1'b1;
          if (nr_take) nr_found_q <= 1'b1;
          if (scan_done) state_q <= B_OUT;
        end
        B_OUT: begin
          if (slot_free) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    area2_q   <= 32'(e1_q.width) * 32'(e1_q.height);
    eq2_q     <= (e1_q.width == cur_q.mode.width) && (e1_q.height == cur_q.mode.height);
    e2_q      <= e1_q;
    metric3_q <= largest ? area2_q : delta2;
    eq3_q     <= eq2_q;
    e3_q      <= e2_q;
    if ((state_q == B_IDLE && q_valid_i) || (state_q == B_SCAN && scan_done)) begin
      res_q <= res_d;
    end
    if (state_q == B_IDLE && q_valid_i) begin
      cur_q      <= q_cmd_i;
      req_area_q <= 32'(q_cmd_i.mode.width) * 32'(q_cmd_i.mode.height);
      addr_q     <= AW'(count_q - CW'(1));
    end
    if (state_q == B_SCAN) begin
      if (issuing_q && (addr_q != '0)) addr_q <= addr_q - AW'(1);
      if (ex_take) ex_best_q <= e3_q;
      if (nr_take) begin
        nr_best_q   <= e3_q;
        nr_metric_q <= metric3_q;
      end
    end
    if (state_q == B_OUT && slot_free) out_q <= out_d;
  end

endmodule

>>> rtl/core/display_mode_best_match.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o  | in_item_i  (dmbm_pkg::in_item_t)
// out     | output    | out_valid_o/out_stall_i| out_item_o (dmbm_pkg::out_item_t)
// cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (fb_size_limit)
//
// the front holds off new items until the current one is pushed (capture, pitch*height, times bpp and check)
// clear and add items pass from the two-entry queue through the back state register to the output register
// match and largest scan the table in the back: one table read a cycle
// through the single read port, then a 3-stage area / distance pipeline
// reset empties the table count and the queue and sets fb_size_limit to 16777216
// a stalled output holds its item while the front and queue keep accepting until the queue is full
module display_mode_best_match #(
  parameter int MAX_MODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dmbm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dmbm_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  // framebuffer size limit register, always writable
  logic [31:0]    fb_limit_q;
  logic           push, full, q_valid, q_pop;
  dmbm_pkg::cmd_t push_cmd, q_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_limit_q <= dmbm_pkg::FB_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      fb_limit_q <= cfg_data_i;
    end
  end

  // front: accept and classify (eligibility of add items)
  dmbm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .fb_limit_i (fb_limit_q),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  // short queue between front and back
  dmbm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd),
    .pop_i      (q_pop)
  );

  // back: table updates, scans and the output register
  dmbm_back #(
    .MAX_MODES (MAX_MODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
